// File: src/sspq_pkg.sv
// Shared types and constants for the sorted shift priority queue.
`default_nettype none

package sspq_pkg;

  localparam int unsigned KeyW       = 16;
  localparam int unsigned ValW       = 16;
  localparam int unsigned DepthDflt  = 16;
  localparam logic [KeyW-1:0] EmptyKey = {KeyW{1'b1}};

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } sspq_func_e;

  typedef struct packed {
    sspq_func_e      func;
    logic [KeyW-1:0] in_key;
    logic [ValW-1:0] in_value;
  } sspq_req_t;

  typedef struct packed {
    logic [KeyW-1:0] out_key;
    logic [ValW-1:0] out_value;
    logic            out_valid;
    logic            is_full;
    logic            is_empty;
  } sspq_rsp_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] val;
  } sspq_entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic            en;
    sspq_func_e      func;
    sspq_entry_t     entry;
  } sspq_cmd_t;

  localparam sspq_entry_t EmptyEntry = '{key: EmptyKey, val: '0};

endpackage

`default_nettype wire

// File: src/sorted_shift_priority_queue.sv
// Sorted shift priority queue: top level with the chain of slot cells.
// The result beat appears on rsp_o with done_o in the cycle after start is taken.
// Throughput: one access per cycle; every cell decides locally from one key compare,
// so busy stays low and the receiver cannot stall the result beat.
// Reset: all slots hold the reserved empty key and zero value; no beat is pending.
// Flags in the result beat reflect the slot contents right after the access.
`default_nettype none

module sorted_shift_priority_queue
  import sspq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDflt
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output      logic      busy,
  input  wire sspq_req_t req_i,
  output      logic      done_o,
  output      sspq_rsp_t rsp_o
);

  sspq_cmd_t   cmd;
  sspq_entry_t slot [DEPTH];
  logic        gt   [DEPTH];

  logic            done_q;
  logic [KeyW-1:0] out_key_q;
  logic [ValW-1:0] out_value_q;
  logic            out_valid_q;
  logic            accept;

  // Every access completes before the next can be taken, so never hold off a start.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Broadcast the request to every cell.
  assign cmd.en        = accept;
  assign cmd.func      = req_i.func;
  assign cmd.entry.key = req_i.in_key;
  assign cmd.entry.val = req_i.in_value;

  // Build the chain: slot 0 has no left neighbor, the last slot refills with empty.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sspq_entry_t left_ent;
    sspq_entry_t right_ent;
    logic        left_gt;

    if (i == 0) begin : g_head
      assign left_ent = EmptyEntry;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_ent = slot[i-1];
      assign left_gt  = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = EmptyEntry;
    end else begin : g_inner
      assign right_ent = slot[i+1];
    end

    sspq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_i    (left_ent),
      .left_gt_i (left_gt),
      .right_i   (right_ent),
      .entry_o   (slot[i]),
      .gt_o      (gt[i])
    );
  end

  // Capture the head slot on a dequeue; an enqueue reports nothing removed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        out_valid_q <= (req_i.func == FUNC_DEQ) && (slot[0].key != EmptyKey);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (req_i.func == FUNC_DEQ) begin
        out_key_q   <= slot[0].key;
        out_value_q <= slot[0].val;
      end else begin
        out_key_q   <= EmptyKey;
        out_value_q <= '0;
      end
    end
  end

  // Flags come straight from the end slots, which already hold the post-access state.
  assign done_o          = done_q;
  assign rsp_o.out_key   = out_key_q;
  assign rsp_o.out_value = out_value_q;
  assign rsp_o.out_valid = out_valid_q;
  assign rsp_o.is_full   = slot[DEPTH-1].key != EmptyKey;
  assign rsp_o.is_empty  = slot[0].key == EmptyKey;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rsp_o.is_full && rsp_o.is_empty))
    else $error("queue reports full and empty at once");

  a_valid_only_on_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.func == FUNC_ENQ) |=> done_o && !rsp_o.out_valid
      && (rsp_o.out_key == EmptyKey))
    else $error("enqueue beat reports a removed entry");

  a_deq_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.func == FUNC_DEQ) && (slot[0].key != EmptyKey)
      |=> rsp_o.out_valid && (rsp_o.out_key == $past(slot[0].key)))
    else $error("dequeue did not return the head slot");

  for (genvar j = 1; j < DEPTH; j++) begin : g_sorted_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      slot[j-1].key <= slot[j].key)
      else $error("slot chain out of order");
  end

endmodule

`default_nettype wire

// File: src/sspq_cell.sv
// One slot of the sorted chain: compare with the broadcast key, shift with neighbors.
`default_nettype none

module sspq_cell
  import sspq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire sspq_cmd_t   cmd_i,
  input  wire sspq_entry_t left_i,
  input  wire logic        left_gt_i,
  input  wire sspq_entry_t right_i,
  output      sspq_entry_t entry_o,
  output      logic        gt_o
);

  sspq_entry_t entry_q, entry_d;

  // A freed slot compares greater than any legal key, so a new entry lands in the first
  // larger-keyed slot; a reserved key never compares greater, so it changes nothing.
  assign gt_o = entry_q.key > cmd_i.entry.key;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.en) begin
      unique case (cmd_i.func)
        FUNC_ENQ: begin
          // Take the left entry if it also moves up, else the new one lands here.
          if (gt_o && left_gt_i) begin
            entry_d = left_i;
          end else if (gt_o) begin
            entry_d = cmd_i.entry;
          end
        end
        FUNC_DEQ: begin
          entry_d = right_i;
        end
        default: entry_d = entry_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= EmptyEntry;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire
